// ===== hdl/ikws_pkg.sv =====
package ikws_pkg;

	localparam int KW_COUNT     = 37;
	localparam int KW_MAX_LEN   = 10;
	localparam int KW_IDX_W     = 4;
	localparam int KIND_W       = 6;
	localparam int POS_W        = 24;
	localparam int COL_W        = 16;
	localparam int LINE_W       = 20;
	localparam int LEN_BITS_DEF = 16;

	localparam logic [KIND_W-1:0] KIND_IDENT = '0;

	typedef logic [KW_COUNT-1:0]   cand_t;
	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [COL_W-1:0]      col_t;
	typedef logic [LINE_W-1:0]     line_t;
	typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;

	typedef struct packed {
		kind_t kind;
		line_t tok_line;
		col_t  tok_column;
		col_t  end_column;
		pos_t  start_pos;
		pos_t  end_pos;
		logic  too_long;
	} token_t;

	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		"if", "elif", "else", "match", "for", "while", "forever", "break",
		"continue", "mut", "def", "return", "true", "false", "_", "class",
		"public", "private", "protected", "abstract", "extends", "implements",
		"interface", "new", "self", "super", "instanceof", "try", "catch",
		"finally", "throw", "enum", "or", "propagate", "err", "None", "in"
	};

	localparam logic [KW_IDX_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd5, 4'd7, 4'd5, 4'd8, 4'd3, 4'd3,
		4'd6, 4'd4, 4'd5, 4'd1, 4'd5, 4'd6, 4'd7, 4'd9, 4'd8, 4'd7, 4'd10,
		4'd9, 4'd3, 4'd4, 4'd5, 4'd10, 4'd3, 4'd5, 4'd7, 4'd5, 4'd4, 4'd2,
		4'd9, 4'd3, 4'd4, 4'd2
	};

	// Character idx of keyword k; string literals are right-aligned in KW_TEXT.
	function automatic logic [7:0] kw_byte(input int k, input logic [KW_IDX_W-1:0] idx);
		logic [KW_IDX_W-1:0] p;
		logic [7:0]          b;
		p = KW_LEN[k] - idx - KW_IDX_W'(1);
		b = 8'h00;
		if (idx < KW_LEN[k]) begin
			b = KW_TEXT[k][{p, 3'b000} +: 8];
		end
		return b;
	endfunction

	function automatic logic is_start_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_body_char(input logic [7:0] c);
		return is_start_char(c) || (c >= "0" && c <= "9");
	endfunction

endpackage

// ===== hdl/ikws_kw_match.sv =====
module ikws_kw_match #(
	parameter int LEN_BITS = ikws_pkg::LEN_BITS_DEF
) (
	input  ikws_pkg::cand_t      cand,
	input  logic [LEN_BITS-1:0]  len,
	input  logic [7:0]           ch,
	input  logic                 overflow,
	output ikws_pkg::cand_t      cand_next,
	output ikws_pkg::kind_t      kind
);
	import ikws_pkg::*;

	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			cand_next[k] = cand[k] && (len < LEN_BITS'(KW_LEN[k])) &&
				(kw_byte(k, len[KW_IDX_W-1:0]) == ch);
		end
	end

	always_comb begin
		kind = KIND_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (cand[k] && len == LEN_BITS'(KW_LEN[k])) begin
				kind = KIND_W'(k + 1);
			end
		end
		if (overflow) begin
			kind = KIND_IDENT;
		end
	end

endmodule

// ===== hdl/ikws_scan.sv =====
module ikws_scan #(
	parameter int LEN_BITS = ikws_pkg::LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [7:0]        ch,
	input  logic              is_end,
	input  ikws_pkg::pos_t    char_pos,
	input  ikws_pkg::col_t    char_column,
	input  ikws_pkg::line_t   char_line,
	output logic              emit,
	output ikws_pkg::token_t  tok
);
	import ikws_pkg::*;

	localparam int SUM_W = ((LEN_BITS > POS_W) ? LEN_BITS : POS_W) + 1;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
	localparam col_t COL_MAX = '1;
	localparam pos_t POS_MAX = '1;

	logic                in_ident_q;
	cand_t               cand_q;
	logic [LEN_BITS-1:0] len_q;
	logic                ovf_q;
	pos_t                first_pos_q;
	col_t                first_column_q;
	line_t               first_line_q;

	logic                body;
	logic                start;
	cand_t               cand_in;
	logic [LEN_BITS-1:0] len_in;
	logic                ovf_in;
	cand_t               cand_next;
	logic [LEN_BITS-1:0] len_next;
	logic                ovf_next;
	kind_t               kind;
	logic [SUM_W-1:0]    ec_sum;
	logic [SUM_W-1:0]    ep_sum;

	assign body  = !is_end && is_body_char(ch);
	assign start = !is_end && is_start_char(ch);
	assign emit  = in_ident_q && !body;

	assign cand_in = in_ident_q ? cand_q : '1;
	assign len_in  = in_ident_q ? len_q : '0;
	assign ovf_in  = in_ident_q && ovf_q;

	ikws_kw_match #(.LEN_BITS(LEN_BITS)) u_step (
		.cand      (cand_in),
		.len       (len_in),
		.ch        (ch),
		.overflow  (ovf_in),
		.cand_next (cand_next),
		.kind      ()
	);

	ikws_kw_match #(.LEN_BITS(LEN_BITS)) u_close (
		.cand      (cand_q),
		.len       (len_q),
		.ch        (ch),
		.overflow  (ovf_q),
		.cand_next (),
		.kind      (kind)
	);

	assign ovf_next = ovf_in || (len_in == LEN_MAX);
	assign len_next = (len_in == LEN_MAX) ? len_in : len_in + LEN_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ident_q <= 1'b0;
			cand_q     <= '1;
			len_q      <= '0;
			ovf_q      <= 1'b0;
		end else if (go) begin
			if (emit) begin
				in_ident_q <= 1'b0;
				cand_q     <= '1;
				len_q      <= '0;
				ovf_q      <= 1'b0;
			end else if (in_ident_q || start) begin
				in_ident_q <= 1'b1;
				cand_q     <= cand_next;
				len_q      <= len_next;
				ovf_q      <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !in_ident_q && start) begin
			first_pos_q    <= char_pos;
			first_column_q <= char_column;
			first_line_q   <= char_line;
		end
	end

	assign ec_sum = SUM_W'(first_column_q) + SUM_W'(len_q);
	assign ep_sum = SUM_W'(first_pos_q) + SUM_W'(len_q);

	always_comb begin
		tok.kind         = kind;
		tok.tok_line     = first_line_q;
		tok.tok_column   = first_column_q;
		tok.end_column   = (ec_sum > SUM_W'(COL_MAX)) ? COL_MAX : ec_sum[COL_W-1:0];
		tok.start_pos    = first_pos_q;
		tok.end_pos      = (ep_sum > SUM_W'(POS_MAX)) ? POS_MAX : ep_sum[POS_W-1:0];
		tok.too_long     = ovf_q;
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ident_q |-> (cand_q == '1 && len_q == '0 && !ovf_q))
		else $error("Idle scanner state is not cleared.");

	a_ovf_len: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LEN_MAX)
		else $error("Length overflow flag set below the saturation count.");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_ident_q |-> len_q != '0)
		else $error("Open identifier has zero length.");

endmodule

// ===== hdl/identifier_keyword_scanner_core.sv =====
// Scans a source byte stream for identifiers and keywords at one byte per clock. Each transfer
// carries a byte with its offset, column and line; an identifier opens on a letter or underscore
// while idle, runs over letters, digits and underscores, and is closed by any other byte or by an
// end-of-input transfer, which then produces one token: kind 0 for a plain identifier or 1 to 37
// for a keyword, with its line, start and end column and offset. The closing byte never opens a
// new identifier. Bytes pass an input register and the state update into a result register
// that holds the token; the only throttle is a stalled result register, which holds back only
// a byte that would close an identifier.
module identifier_keyword_scanner_core #(
	parameter int LEN_BITS = ikws_pkg::LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        ch,
	input  logic              is_end,
	input  ikws_pkg::pos_t    char_pos,
	input  ikws_pkg::col_t    char_column,
	input  ikws_pkg::line_t   char_line,
	output logic              out_valid,
	input  logic              out_stall,
	output ikws_pkg::kind_t   kind,
	output ikws_pkg::line_t   tok_line,
	output ikws_pkg::col_t    tok_column,
	output ikws_pkg::col_t    end_column,
	output ikws_pkg::pos_t    start_pos,
	output ikws_pkg::pos_t    end_pos,
	output logic              too_long
);
	import ikws_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       is_end_s1;
	pos_t       char_pos_s1;
	col_t       char_column_s1;
	line_t      char_line_s1;

	logic       out_valid_q;
	token_t     tok_q;

	logic       emit;
	token_t     tok;
	logic       out_blocked;
	logic       go;

	assign out_blocked = out_valid_q && out_stall;
	assign go          = valid_s1 && !(emit && out_blocked);
	assign in_stall    = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1          <= ch;
			is_end_s1      <= is_end;
			char_pos_s1    <= char_pos;
			char_column_s1 <= char_column;
			char_line_s1   <= char_line;
		end
	end

	ikws_scan #(.LEN_BITS(LEN_BITS)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.ch          (ch_s1),
		.is_end      (is_end_s1),
		.char_pos    (char_pos_s1),
		.char_column (char_column_s1),
		.char_line   (char_line_s1),
		.emit        (emit),
		.tok         (tok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			tok_q <= tok;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = tok_q.kind;
	assign tok_line     = tok_q.tok_line;
	assign tok_column   = tok_q.tok_column;
	assign end_column   = tok_q.end_column;
	assign start_pos    = tok_q.start_pos;
	assign end_pos      = tok_q.end_pos;
	assign too_long     = tok_q.too_long;

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("Input stalled without a held byte and a pending token.");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> tok_q.kind <= KIND_W'(KW_COUNT))
		else $error("Token kind out of range.");

	a_long_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tok_q.too_long) |-> tok_q.kind == KIND_IDENT)
		else $error("Saturated token reported as a keyword.");

endmodule

// ===== verif/tb_identifier_keyword_scanner_core.sv =====
module tb_identifier_keyword_scanner_core;
	import ikws_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ch;
	logic        is_end;
	pos_t        char_pos;
	col_t        char_column;
	line_t       char_line;
	logic        out_valid;
	logic        out_stall;
	kind_t       kind;
	line_t       tok_line;
	col_t        tok_column;
	col_t        end_column;
	pos_t        start_pos;
	pos_t        end_pos;
	logic        too_long;

	identifier_keyword_scanner_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.is_end(is_end),
		.char_pos(char_pos),
		.char_column(char_column),
		.char_line(char_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.tok_line(tok_line),
		.tok_column(tok_column),
		.end_column(end_column),
		.start_pos(start_pos),
		.end_pos(end_pos),
		.too_long(too_long)
	);

	string kw_words [KW_COUNT] = '{
		"if", "elif", "else", "match", "for", "while", "forever", "break",
		"continue", "mut", "def", "return", "true", "false", "_", "class",
		"public", "private", "protected", "abstract", "extends", "implements",
		"interface", "new", "self", "super", "instanceof", "try", "catch",
		"finally", "throw", "enum", "or", "propagate", "err", "None", "in"
	};

	// Predicted scanner state.
	logic                    scanning = 1'b0;
	cand_t                   cands = '1;
	logic [LEN_BITS_DEF-1:0] ident_len = '0;
	logic                    len_saturated = 1'b0;
	pos_t                    tok_pos = '0;
	col_t                    tok_col = '0;
	line_t                   tok_ln = '0;

	token_t pending_tokens [$];
	token_t due_tok;

	pos_t  cur_pos = '0;
	col_t  cur_col = '0;
	line_t cur_line = '0;

	bit          quiet = 1'b0;
	bit          sender_gaps = 1'b1;
	int          hold_request = 0;
	int          mismatches = 0;
	int          items_sent = 0;
	int          stall_cycles = 0;
	int          tokens_checked = 0;
	int          keywords_checked = 0;
	int          saturated_checked = 0;
	logic [37:0] kinds_seen = '0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit opens_ident(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit continues_ident(input logic [7:0] c);
		return opens_ident(c) || (c >= "0" && c <= "9");
	endfunction

	function automatic logic [7:0] rand_start_char();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return 8'(97 + r);
		if (r < 52) return 8'(65 + r - 26);
		return "_";
	endfunction

	function automatic logic [7:0] rand_body_char();
		if ($urandom_range(0, 4) == 0) return 8'(48 + $urandom_range(0, 9));
		return rand_start_char();
	endfunction

	function automatic logic [7:0] rand_separator();
		logic [7:0] c;
		if ($urandom_range(0, 5) == 0) return 8'h0a;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (continues_ident(c));
		return c;
	endfunction

	task automatic absorb_char(input logic [7:0] c);
		for (int k = 0; k < KW_COUNT; k++) begin
			if (cands[k] && (ident_len >= kw_words[k].len() || kw_words[k][ident_len] != c)) begin
				cands[k] = 1'b0;
			end
		end
		if (ident_len == '1) begin
			len_saturated = 1'b1;
		end else begin
			ident_len = ident_len + 1'b1;
		end
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic e, input pos_t p,
			input col_t col, input line_t ln);
		token_t      tok;
		logic [16:0] ec;
		logic [24:0] ep;
		if (scanning) begin
			if (!e && continues_ident(c)) begin
				absorb_char(c);
			end else begin
				tok.kind = KIND_IDENT;
				if (!len_saturated) begin
					for (int k = 0; k < KW_COUNT; k++) begin
						if (tok.kind == KIND_IDENT && cands[k] && ident_len == kw_words[k].len()) begin
							tok.kind = kind_t'(k + 1);
						end
					end
				end
				ec = {1'b0, tok_col} + 17'(ident_len);
				if (ec > 17'h0FFFF) ec = 17'h0FFFF;
				ep = {1'b0, tok_pos} + 25'(ident_len);
				if (ep > 25'h0FFFFFF) ep = 25'h0FFFFFF;
				tok.tok_line = tok_ln;
				tok.tok_column = tok_col;
				tok.end_column = ec[15:0];
				tok.start_pos = tok_pos;
				tok.end_pos = ep[23:0];
				tok.too_long = len_saturated;
				pending_tokens.push_back(tok);
				scanning = 1'b0;
				cands = '1;
				ident_len = '0;
				len_saturated = 1'b0;
			end
		end else if (!e && opens_ident(c)) begin
			scanning = 1'b1;
			cands = '1;
			ident_len = '0;
			len_saturated = 1'b0;
			tok_pos = p;
			tok_col = col;
			tok_ln = ln;
			absorb_char(c);
		end
	endtask

	task automatic send_byte(input logic [7:0] c, input logic e);
		int gap;
		@(negedge clk);
		if (sender_gaps && !quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		is_end <= e;
		char_pos <= cur_pos;
		char_column <= cur_col;
		char_line <= cur_line;
		do begin
			@(posedge clk);
			if (in_stall) stall_cycles++;
		end while (in_stall);
		predict_byte(c, e, cur_pos, cur_col, cur_line);
		items_sent++;
		if (!e) begin
			cur_pos = cur_pos + 1'b1;
			if (c == 8'h0a) begin
				cur_line = cur_line + 1'b1;
				cur_col = '0;
			end else begin
				cur_col = cur_col + 1'b1;
			end
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], 1'b0);
		end
	endtask

	task automatic send_variant(input string w);
		case ($urandom_range(0, 2))
			0: begin
				if (w.len() == 1) begin
					send_text("__");
				end else begin
					for (int i = 0; i < w.len() - 1; i++) send_byte(w[i], 1'b0);
				end
			end
			1: begin
				send_text(w);
				send_byte(rand_body_char(), 1'b0);
			end
			default: begin
				send_byte((w[0] == "_") ? 8'h5f : (w[0] ^ 8'h20), 1'b0);
				for (int i = 1; i < w.len(); i++) send_byte(w[i], 1'b0);
			end
		endcase
	endtask

	task automatic send_close();
		if ($urandom_range(0, 9) == 0) begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_byte(rand_separator(), 1'b0);
		end
	endtask

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		if (mismatches <= 40) begin
			$display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch("token with nothing pending, kind", 0, kind);
			end else begin
				due_tok = pending_tokens.pop_front();
				if (kind !== due_tok.kind) report_mismatch("kind", due_tok.kind, kind);
				if (tok_line !== due_tok.tok_line) report_mismatch("tok_line", due_tok.tok_line, tok_line);
				if (tok_column !== due_tok.tok_column)
					report_mismatch("tok_column", due_tok.tok_column, tok_column);
				if (end_column !== due_tok.end_column)
					report_mismatch("end_column", due_tok.end_column, end_column);
				if (start_pos !== due_tok.start_pos) report_mismatch("start_pos", due_tok.start_pos, start_pos);
				if (end_pos !== due_tok.end_pos) report_mismatch("end_pos", due_tok.end_pos, end_pos);
				if (too_long !== due_tok.too_long) report_mismatch("too_long", due_tok.too_long, too_long);
				tokens_checked++;
				if (due_tok.kind != KIND_IDENT) keywords_checked++;
				if (due_tok.too_long) saturated_checked++;
				kinds_seen[due_tok.kind] = 1'b1;
			end
		end
	end

	initial begin
		int hold_left;
		int burst_left;
		hold_left = 0;
		burst_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left != 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(0, 18);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_directed_cases();
		send_byte("7", 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte("a", 1'b1);
		send_byte("_", 1'b0);
		send_byte("b", 1'b1);
		send_byte(")", 1'b0);
		cur_pos = '0;
		cur_col = 16'd65533;
		cur_line = '0;
		send_text("if");
		send_byte(8'h80, 1'b0);
		cur_pos = 24'hfffffe;
		cur_col = 16'hffff;
		cur_line = 20'hfffff;
		send_text("elif");
		send_byte(8'h0a, 1'b0);
		cur_pos = '0;
		cur_col = '0;
		cur_line = '0;
		send_text("a9Z");
		send_byte(" ", 1'b0);
		send_text("None");
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_keyword_sweep();
		for (int k = 0; k < KW_COUNT; k++) begin
			send_text(kw_words[k]);
			send_close();
		end
	endtask

	task automatic test_length_limit();
		sender_gaps = 1'b0;
		cur_pos = 24'hfffff0;
		cur_col = 16'hff00;
		send_byte(rand_start_char(), 1'b0);
		repeat (65534) send_byte(rand_body_char(), 1'b0);
		send_byte(" ", 1'b0);
		cur_pos = '0;
		cur_col = '0;
		send_text("if");
		repeat (65534) send_byte(rand_body_char(), 1'b0);
		send_byte("q", 1'b1);
		sender_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		sender_gaps = 1'b0;
		hold_request = 200;
		repeat (40) begin
			send_byte(rand_start_char(), 1'b0);
			send_byte(";", 1'b0);
		end
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_text();
		int useful;
		int before_cnt;
		int r;
		useful = 0;
		while (useful < 650) begin
			if (useful > 550) quiet = 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				cur_pos = pos_t'($urandom);
				cur_col = col_t'($urandom);
				cur_line = line_t'($urandom);
				if ($urandom_range(0, 7) == 0) begin
					cur_pos = 24'hffffff - 24'($urandom_range(0, 12));
					cur_col = 16'hffff - 16'($urandom_range(0, 12));
				end
			end
			before_cnt = items_sent;
			r = $urandom_range(0, 9);
			if (r < 4) begin
				send_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
			end else if (r < 6) begin
				send_variant(kw_words[$urandom_range(0, KW_COUNT - 1)]);
			end else if (r < 9) begin
				send_byte(rand_start_char(), 1'b0);
				repeat ($urandom_range(0, 11)) send_byte(rand_body_char(), 1'b0);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1) == 0) send_byte(8'(48 + $urandom_range(0, 9)), 1'b0);
					else send_byte(rand_separator(), 1'($urandom_range(0, 1)));
				end
				continue;
			end
			send_close();
			useful += items_sent - before_cnt;
			if ($urandom_range(0, 2) == 0) send_byte(rand_separator(), 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		is_end = 1'b0;
		char_pos = '0;
		char_column = '0;
		char_line = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_keyword_sweep();
		test_length_limit();
		test_backpressure();
		test_random_text();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes; checked %0d tokens, %0d keywords over %0d distinct kinds.",
			items_sent, tokens_checked, keywords_checked, $countones(kinds_seen));
		$display("Over-length tokens: %0d; input held off for %0d cycles.",
			saturated_checked, stall_cycles);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== identifier_keyword_scanner_core.f =====
hdl/ikws_pkg.sv
hdl/ikws_kw_match.sv
hdl/ikws_scan.sv
hdl/identifier_keyword_scanner_core.sv
verif/tb_identifier_keyword_scanner_core.sv
